// ----- rtl/ppid_pkg.sv -----
`timescale 1ns / 1ps
package ppid_pkg;

    localparam int Q_DEPTH = 4;

    localparam logic [2:0] CFG_IMAGE_WIDTH      = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_COUNT    = 3'd2;
    localparam logic [2:0] CFG_WIDE_SAMPLES     = 3'd3;
    localparam logic [2:0] CFG_COMPRESSION_MODE = 3'd4;

    localparam logic [1:0] MODE_RAW = 2'd0;
    localparam logic [1:0] MODE_RLE = 2'd1;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CROSS = 2'd1;
    localparam logic [1:0] ERR_UNSUP = 2'd2;

    typedef struct packed {
        logic        wide;
        logic [1:0]  mode;
        logic [5:0]  chan;
        logic [19:0] line_len;
        logic [24:0] lines;
        logic [25:0] tbl_len;
        logic [36:0] plane;
    } t_cfg;

    typedef struct packed {
        logic [15:0] value;
        logic [36:0] pos;
        logic [5:0]  ch;
        logic [7:0]  count;
        logic [1:0]  err;
        logic        done;
        logic        last;
    } t_res;

    typedef struct packed {
        t_res a;
        t_res b;
        logic two;
    } t_pair;

endpackage

// ----- rtl/planar_packbits_image_decoder_unit.sv -----
`timescale 1ns / 1ps
// Planar PackBits image decoder. Takes one byte of the image data section per
// cycle while the input is not stalled, and emits sample-fill words at interleaved
// indices. A byte that yields two words (a sixteen-bit repeat run that completes
// a pending high byte) occupies one entry of a four-entry queue between the byte
// parser and the index stage, which emits the two words in turn. Input stalls in
// the cycle after every configuration write, and after reset, while the derived
// sizes (w*h, h*c, line length) settle, and also while the queue is full. An
// accepted byte's words pass through the queue and then the output register.
module planar_packbits_image_decoder_unit #(
    parameter int MAX_DIMENSION = 300000,
    parameter int MAX_CHANNELS  = 56
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [18:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_sample_value,
    output logic [42:0] o_first_index,
    output logic [7:0]  o_sample_count,
    output logic [1:0]  o_error_code,
    output logic        o_image_done,
    output logic        o_last
);

    localparam logic [18:0] MAX_W = 19'(MAX_DIMENSION);
    localparam logic [5:0]  MAX_C = 6'(MAX_CHANNELS);

    logic [18:0]     r_width, r_height, w_c, h_c;
    logic [5:0]      r_chan, c_c;
    logic            r_wide;
    logic [1:0]      r_mode;
    logic            r_settle;
    ppid_pkg::t_cfg  r_cfg, n_cfg;
    logic [36:0]     plane_full;
    logic [24:0]     lines;

    logic            accept, push, pop, q_empty, q_full;
    ppid_pkg::t_pair push_pair, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 19'd1;
            r_height <= 19'd1;
            r_chan   <= 6'd1;
            r_wide   <= 1'b0;
            r_mode   <= ppid_pkg::MODE_RAW;
            r_settle <= 1'b1;
        end else begin
            r_settle <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ppid_pkg::CFG_IMAGE_WIDTH:      r_width  <= i_cfg_data;
                    ppid_pkg::CFG_IMAGE_HEIGHT:     r_height <= i_cfg_data;
                    ppid_pkg::CFG_CHANNEL_COUNT:    r_chan   <= i_cfg_data[5:0];
                    ppid_pkg::CFG_WIDE_SAMPLES:     r_wide   <= i_cfg_data[0];
                    ppid_pkg::CFG_COMPRESSION_MODE: r_mode   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        w_c = (r_width == '0) ? 19'd1 : ((r_width > MAX_W) ? MAX_W : r_width);
        h_c = (r_height == '0) ? 19'd1 : ((r_height > MAX_W) ? MAX_W : r_height);
        c_c = (r_chan == '0) ? 6'd1 : ((r_chan > MAX_C) ? MAX_C : r_chan);
        plane_full = 37'(w_c) * 37'(h_c);
        lines      = 25'(h_c) * 25'(c_c);
        n_cfg.wide     = r_wide;
        n_cfg.mode     = r_mode;
        n_cfg.chan     = c_c;
        n_cfg.line_len = r_wide ? {w_c, 1'b0} : {1'b0, w_c};
        n_cfg.lines    = lines;
        n_cfg.tbl_len  = {lines, 1'b0};
        n_cfg.plane    = plane_full;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_in_stall = r_settle || q_full;
    assign accept     = i_in_valid && !o_in_stall;

    ppid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .i_cfg       (r_cfg),
        .o_push      (push),
        .o_pair      (push_pair)
    );

    ppid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_pair),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ppid_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .i_chan         (r_cfg.chan),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value),
        .o_first_index  (o_first_index),
        .o_sample_count (o_sample_count),
        .o_error_code   (o_error_code),
        .o_image_done   (o_image_done),
        .o_last         (o_last)
    );

endmodule

// ----- rtl/ppid_front.sv -----
`timescale 1ns / 1ps
module ppid_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first,
    input  ppid_pkg::t_cfg  i_cfg,
    output logic            o_push,
    output ppid_pkg::t_pair o_pair
);

    typedef enum logic [2:0] {
        PH_START, PH_RAW, PH_TABLE, PH_HEADER, PH_REPEAT, PH_LITERAL, PH_DONE, PH_HALT
    } t_phase;

    t_phase      r_phase, s_phase, n_phase, f_phase;
    logic [25:0] r_tbl, s_tbl, n_tbl, tbl_dec;
    logic [19:0] r_line, s_line, n_line, line_pre;
    logic [7:0]  r_lit, s_lit, n_lit, lit_dec;
    logic [7:0]  r_pend, s_pend, n_pend;
    logic        r_pv, s_pv, n_pv;
    logic [36:0] r_pos, s_pos, n_pos;
    logic [5:0]  r_ch, s_ch, n_ch;
    logic [24:0] r_scan, s_scan, n_scan, scan_dec;

    logic        restart, err_en, feed, line_chk, fin_line;
    logic [1:0]  err_val;
    logic        rep;
    logic [7:0]  hdr_k, rem;
    logic        put1_req, put2_req;
    logic [15:0] put1_val, put2_val;
    logic [7:0]  put1_cnt, put2_cnt;

    logic [36:0] sum1, pos1, sum2x, sum2;
    logic        wrap1, done1, p2, wrap2, done2, finished;
    logic [5:0]  ch1;
    ppid_pkg::t_res res1, res2, res_err;

    always_comb begin
        restart = i_first || (r_phase == PH_START);
        err_en  = 1'b0;
        err_val = ppid_pkg::ERR_NONE;
        if (restart) begin
            s_tbl  = i_cfg.tbl_len;
            s_line = i_cfg.line_len;
            s_lit  = '0;
            s_pend = '0;
            s_pv   = 1'b0;
            s_pos  = '0;
            s_ch   = '0;
            s_scan = i_cfg.lines;
            case (i_cfg.mode)
                ppid_pkg::MODE_RAW: s_phase = PH_RAW;
                ppid_pkg::MODE_RLE: s_phase = PH_TABLE;
                default: begin
                    s_phase = PH_HALT;
                    err_en  = 1'b1;
                    err_val = ppid_pkg::ERR_UNSUP;
                end
            endcase
        end else begin
            s_phase = r_phase;
            s_tbl   = r_tbl;
            s_line  = r_line;
            s_lit   = r_lit;
            s_pend  = r_pend;
            s_pv    = r_pv;
            s_pos   = r_pos;
            s_ch    = r_ch;
            s_scan  = r_scan;
        end

        rep   = (i_data_byte == 8'h00) || (i_data_byte > 8'h80);
        hdr_k = (i_data_byte == 8'h00) ? 8'd1 :
                rep ? 8'(9'd257 - {1'b0, i_data_byte}) : 8'(i_data_byte + 8'd1);

        n_phase  = s_phase;
        n_tbl    = s_tbl;
        n_lit    = s_lit;
        n_pend   = s_pend;
        n_pv     = s_pv;
        n_scan   = s_scan;
        line_pre = s_line;
        line_chk = 1'b0;
        feed     = 1'b0;
        put1_req = 1'b0;
        put1_val = {8'h00, i_data_byte};
        put1_cnt = 8'd1;
        put2_req = 1'b0;
        put2_val = {i_data_byte, i_data_byte};
        put2_cnt = '0;
        tbl_dec  = (s_tbl != '0) ? s_tbl - 26'd1 : s_tbl;
        lit_dec  = (s_lit != '0) ? s_lit - 8'd1 : s_lit;
        rem      = s_lit - {7'd0, s_pv};

        unique case (s_phase) inside
            PH_RAW: feed = 1'b1;
            PH_TABLE: begin
                n_tbl = tbl_dec;
                if (tbl_dec == '0) n_phase = PH_HEADER;
            end
            PH_HEADER: begin
                if (i_data_byte != 8'h80) begin
                    if ({12'd0, hdr_k} > s_line) begin
                        err_en  = 1'b1;
                        err_val = ppid_pkg::ERR_CROSS;
                        n_phase = PH_HALT;
                    end else begin
                        n_lit   = hdr_k;
                        n_phase = rep ? PH_REPEAT : PH_LITERAL;
                    end
                end
            end
            PH_REPEAT: begin
                if (!i_cfg.wide) begin
                    put1_req = 1'b1;
                    put1_cnt = s_lit;
                end else begin
                    put1_req = s_pv;
                    put1_val = {s_pend, i_data_byte};
                    put2_req = 1'b1;
                    put2_cnt = {1'b0, rem[7:1]};
                    n_pv     = rem[0];
                    if (rem[0]) n_pend = i_data_byte;
                end
                line_pre = s_line - {12'd0, s_lit};
                n_lit    = '0;
                n_phase  = PH_HEADER;
                line_chk = 1'b1;
            end
            PH_LITERAL: begin
                feed     = 1'b1;
                line_pre = (s_line != '0) ? s_line - 20'd1 : s_line;
                n_lit    = lit_dec;
                if (lit_dec == '0) n_phase = PH_HEADER;
                line_chk = 1'b1;
            end
            PH_START, PH_DONE, PH_HALT: ;
        endcase

        if (feed) begin
            if (!i_cfg.wide) begin
                put1_req = 1'b1;
            end else if (!s_pv) begin
                n_pend = i_data_byte;
                n_pv   = 1'b1;
            end else begin
                put1_req = 1'b1;
                put1_val = {s_pend, i_data_byte};
                n_pv     = 1'b0;
            end
        end

        n_line   = line_pre;
        fin_line = 1'b0;
        scan_dec = (s_scan != '0) ? s_scan - 25'd1 : s_scan;
        if (line_chk && (line_pre == '0)) begin
            n_scan = scan_dec;
            if (scan_dec == '0) fin_line = 1'b1;
            else n_line = i_cfg.line_len;
        end
    end

    // both position updates are formed side by side
    always_comb begin
        sum1  = s_pos + 37'(put1_cnt);
        wrap1 = put1_req && (sum1 >= i_cfg.plane);
        ch1   = wrap1 ? 6'(s_ch + 6'd1) : s_ch;
        done1 = wrap1 && (({1'b0, s_ch} + 7'd1) >= {1'b0, i_cfg.chan});
        pos1  = put1_req ? (wrap1 ? '0 : sum1) : s_pos;
        sum2x = s_pos + 37'(put1_req) + 37'(put2_cnt);
        sum2  = wrap1 ? 37'(put2_cnt) : sum2x;
        p2    = put2_req && (put2_cnt != '0) && !done1;
        wrap2 = p2 && (wrap1 ? (37'(put2_cnt) >= i_cfg.plane) : (sum2x >= i_cfg.plane));
        done2 = wrap2 && (({1'b0, ch1} + 7'd1) >= {1'b0, i_cfg.chan});
        n_pos = p2 ? (wrap2 ? '0 : sum2) : pos1;
        n_ch  = wrap2 ? 6'(ch1 + 6'd1) : ch1;
    end

    always_comb begin
        finished = done1 || done2 || fin_line;
        f_phase  = finished ? PH_DONE : n_phase;

        res1 = '{value: put1_val, pos: s_pos, ch: s_ch, count: put1_cnt,
                 err: ppid_pkg::ERR_NONE, done: done1, last: 1'b0};
        res2 = '{value: put2_val, pos: pos1, ch: ch1, count: put2_cnt,
                 err: ppid_pkg::ERR_NONE, done: done2, last: 1'b1};
        res_err = '{value: '0, pos: '0, ch: '0, count: '0,
                    err: err_val, done: 1'b0, last: 1'b1};

        o_push = i_accept && (err_en || put1_req || p2);
        if (err_en) begin
            o_pair = '{a: res_err, b: res2, two: 1'b0};
        end else if (put1_req) begin
            o_pair = '{a: res1, b: res2, two: p2};
            o_pair.a.last = !p2;
        end else begin
            o_pair = '{a: res2, b: res2, two: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_tbl   <= '0;
            r_line  <= '0;
            r_lit   <= '0;
            r_pend  <= '0;
            r_pv    <= 1'b0;
            r_pos   <= '0;
            r_ch    <= '0;
            r_scan  <= '0;
        end else if (i_accept) begin
            r_phase <= f_phase;
            r_tbl   <= n_tbl;
            r_line  <= n_line;
            r_lit   <= n_lit;
            r_pend  <= n_pend;
            r_pv    <= n_pv;
            r_pos   <= n_pos;
            r_ch    <= n_ch;
            r_scan  <= n_scan;
        end
    end

    a_silent_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_first && (r_phase == PH_DONE || r_phase == PH_HALT)) |-> !o_push)
        else $error("word produced after decoding stopped");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_pair.a.err != ppid_pkg::ERR_NONE) |-> (!o_pair.two && o_pair.a.count == '0))
        else $error("error word paired with samples");

endmodule

// ----- rtl/ppid_queue.sv -----
`timescale 1ns / 1ps
module ppid_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppid_pkg::t_pair i_data,
    input  logic            i_pop,
    output ppid_pkg::t_pair o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = $clog2(ppid_pkg::Q_DEPTH);

    ppid_pkg::t_pair r_mem [ppid_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [PW:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PW+1)'(ppid_pkg::Q_DEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= PW'(r_wr + 1'b1);
            if (i_pop) r_rd <= PW'(r_rd + 1'b1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ----- rtl/ppid_back.sv -----
`timescale 1ns / 1ps
module ppid_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppid_pkg::t_pair i_head,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic [5:0]      i_chan,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [15:0]     o_sample_value,
    output logic [42:0]     o_first_index,
    output logic [7:0]      o_sample_count,
    output logic [1:0]      o_error_code,
    output logic            o_image_done,
    output logic            o_last
);

    logic           r_slot, r_ovalid;
    logic [15:0]    r_value;
    logic [42:0]    r_index;
    logic [7:0]     r_count;
    logic [1:0]     r_err;
    logic           r_done, r_last;
    ppid_pkg::t_res sel;
    logic           take;
    logic [42:0]    idx;

    always_comb begin
        sel   = r_slot ? i_head.b : i_head.a;
        take  = !i_empty && (!r_ovalid || !i_out_stall);
        o_pop = take && (r_slot || !i_head.two);
        idx   = 43'(sel.pos) * 43'(i_chan) + 43'(sel.ch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
            r_slot   <= !o_pop;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= sel.value;
            r_index <= idx;
            r_count <= sel.count;
            r_err   <= sel.err;
            r_done  <= sel.done;
            r_last  <= sel.last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sample_value = r_value;
    assign o_first_index  = r_index;
    assign o_sample_count = r_count;
    assign o_error_code   = r_err;
    assign o_image_done   = r_done;
    assign o_last         = r_last;

    a_second_slot_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot |-> (!i_empty && i_head.two))
        else $error("second result taken from a single-result word");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_err != ppid_pkg::ERR_NONE) |-> (r_last && r_count == '0))
        else $error("error word not final");

endmodule

// ----- tb/sv/tb_planar_packbits_image_decoder_unit.sv -----
`timescale 1ns / 1ps
module tb_planar_packbits_image_decoder_unit;

    localparam longint unsigned MAX_DIM  = 300000;
    localparam longint unsigned MAX_CHAN = 56;
    localparam logic [1:0] MODE_ZIP     = 2'd2;
    localparam logic [1:0] MODE_ZIP_ALT = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BYTES  = 1250;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        PH_START, PH_RAW, PH_TABLE, PH_HEADER, PH_REPEAT, PH_LITERAL, PH_DONE, PH_HALT
    } t_phase;

    typedef struct {
        logic [15:0] value;
        logic [42:0] index;
        logic [7:0]  count;
        logic [1:0]  err;
        logic        done;
        logic        last;
    } t_fill_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = ppid_pkg::CFG_IMAGE_WIDTH;
    logic [18:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_first = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_sample_value;
    logic [42:0] o_first_index;
    logic [7:0]  o_sample_count;
    logic [1:0]  o_error_code;
    logic        o_image_done;
    logic        o_last;

    planar_packbits_image_decoder_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder mirror: registers and decode state
    logic [18:0]   reg_width = 19'd1;
    logic [18:0]   reg_height = 19'd1;
    logic [5:0]    reg_chan = 6'd1;
    logic          reg_wide = 1'b0;
    logic [1:0]    reg_mode = ppid_pkg::MODE_RAW;
    t_phase        dec_phase = PH_START;
    int unsigned   tbl_left = 0;
    int unsigned   line_left = 0;
    int unsigned   run_left = 0;
    int unsigned   lines_left = 0;
    logic [7:0]    pend_hi = '0;
    logic          pend_v = 1'b0;
    logic [36:0]   plane_pos = '0;
    logic [5:0]    cur_ch = '0;
    t_fill_word    step_words [2];
    int            step_count;
    bit            step_finished;

    t_fill_word expected_fills [$];

    int  mismatches = 0;
    int  words_seen = 0;
    int  bytes_sent = 0;
    int  noise_bytes = 0;
    int  images = 0;
    int  quiet_cycles = 0;
    int  hold_request = 0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;

    function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint unsigned eff_w();
        return clamp_dim(64'(reg_width), MAX_DIM);
    endfunction

    function automatic longint unsigned eff_h();
        return clamp_dim(64'(reg_height), MAX_DIM);
    endfunction

    function automatic longint unsigned eff_chan();
        return clamp_dim(64'(reg_chan), MAX_CHAN);
    endfunction

    function automatic int unsigned line_length();
        return 32'(eff_w() * (reg_wide ? 2 : 1));
    endfunction

    function automatic void note_fill(logic [15:0] value, logic [42:0] index,
                                      logic [7:0] count, logic [1:0] err, logic done);
        if (step_count >= 2) return;
        step_words[step_count].value = value;
        step_words[step_count].index = index;
        step_words[step_count].count = count;
        step_words[step_count].err   = err;
        step_words[step_count].done  = done;
        step_words[step_count].last  = 1'b0;
        step_count++;
    endfunction

    function automatic void put_samples(logic [15:0] value, int unsigned count);
        longint unsigned idx;
        longint unsigned area;
        logic done;
        done = 1'b0;
        if (step_finished || count == 0) return;
        idx = plane_pos * eff_chan() + cur_ch;
        plane_pos = plane_pos + 37'(count);
        area = eff_w() * eff_h();
        if (plane_pos >= area) begin
            plane_pos = '0;
            cur_ch = cur_ch + 6'd1;
            if (cur_ch >= eff_chan()) done = 1'b1;
        end
        note_fill(value, idx[42:0], count[7:0], ppid_pkg::ERR_NONE, done);
        if (done) step_finished = 1'b1;
    endfunction

    function automatic void feed_sample_byte(logic [7:0] b);
        if (!reg_wide) begin
            put_samples({8'h00, b}, 1);
        end else if (!pend_v) begin
            pend_hi = b;
            pend_v = 1'b1;
        end else begin
            put_samples({pend_hi, b}, 1);
            pend_v = 1'b0;
        end
    endfunction

    function automatic void fill_run(logic [7:0] v, int unsigned k);
        int unsigned rem;
        rem = k;
        if (!reg_wide) begin
            put_samples({8'h00, v}, k);
            return;
        end
        if (pend_v && rem > 0) begin
            put_samples({pend_hi, v}, 1);
            pend_v = 1'b0;
            rem--;
        end
        put_samples({v, v}, rem / 2);
        if (rem % 2 != 0) begin
            pend_hi = v;
            pend_v = 1'b1;
        end
    endfunction

    function automatic void end_of_line_check();
        if (line_left != 0) return;
        if (lines_left > 0) lines_left--;
        if (lines_left == 0) step_finished = 1'b1;
        else line_left = line_length();
    endfunction

    function automatic void restart_decode();
        longint unsigned lines;
        lines = eff_h() * eff_chan();
        pend_hi = '0;
        pend_v = 1'b0;
        plane_pos = '0;
        cur_ch = '0;
        run_left = 0;
        lines_left = 32'(lines);
        tbl_left = 32'(2 * lines);
        line_left = line_length();
        case (reg_mode)
            ppid_pkg::MODE_RAW: dec_phase = PH_RAW;
            ppid_pkg::MODE_RLE: dec_phase = PH_TABLE;
            default: begin
                note_fill('0, '0, '0, ppid_pkg::ERR_UNSUP, 1'b0);
                dec_phase = PH_HALT;
            end
        endcase
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic f);
        int unsigned bv;
        int unsigned k;
        bit rep;
        bit halted;
        bv = 32'(b);
        halted = 1'b0;
        step_count = 0;
        step_finished = 1'b0;
        if (f || dec_phase == PH_START) begin
            restart_decode();
            if (dec_phase == PH_HALT) halted = 1'b1;
        end
        if (!halted) begin
            case (dec_phase)
                PH_RAW: feed_sample_byte(b);
                PH_TABLE: begin
                    if (tbl_left > 0) tbl_left--;
                    if (tbl_left == 0) dec_phase = PH_HEADER;
                end
                PH_HEADER: begin
                    if (bv != 8'h80) begin
                        rep = (bv == 0) || (bv > 8'h80);
                        k = (bv == 0) ? 1 : (rep ? 257 - bv : bv + 1);
                        if (k > line_left) begin
                            note_fill('0, '0, '0, ppid_pkg::ERR_CROSS, 1'b0);
                            dec_phase = PH_HALT;
                        end else begin
                            run_left = k;
                            dec_phase = rep ? PH_REPEAT : PH_LITERAL;
                        end
                    end
                end
                PH_REPEAT: begin
                    fill_run(b, run_left);
                    line_left -= run_left;
                    run_left = 0;
                    dec_phase = PH_HEADER;
                    end_of_line_check();
                end
                PH_LITERAL: begin
                    feed_sample_byte(b);
                    if (line_left > 0) line_left--;
                    if (run_left > 0) run_left--;
                    if (run_left == 0) dec_phase = PH_HEADER;
                    end_of_line_check();
                end
                default: ;
            endcase
            if (step_finished) dec_phase = PH_DONE;
        end
        if (step_count > 0) step_words[step_count - 1].last = 1'b1;
        for (int i = 0; i < step_count; i++) expected_fills.push_back(step_words[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_words
        t_fill_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            words_seen++;
            if (expected_fills.size() == 0) begin
                report_mismatch("word with nothing pending, index", 64'(o_first_index), '0);
            end else begin
                want = expected_fills.pop_front();
                if (o_sample_value !== want.value)
                    report_mismatch("sample_value", 64'(o_sample_value), 64'(want.value));
                if (o_first_index !== want.index)
                    report_mismatch("first_index", 64'(o_first_index), 64'(want.index));
                if (o_sample_count !== want.count)
                    report_mismatch("sample_count", 64'(o_sample_count), 64'(want.count));
                if (o_error_code !== want.err)
                    report_mismatch("error_code", 64'(o_error_code), 64'(want.err));
                if (o_image_done !== want.done)
                    report_mismatch("image_done", 64'(o_image_done), 64'(want.done));
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     quiet_cycles, expected_fills.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall per word, or one long hold on request
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
            end else begin
                n = out_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_first <= f;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        decode_byte(b, f);
        bytes_sent++;
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            noise_bytes++;
        end
    endtask

    task automatic drain_fills();
        i_in_valid <= 1'b0;
        while (expected_fills.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [2:0] idx, input logic [18:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            ppid_pkg::CFG_IMAGE_WIDTH:      reg_width = val;
            ppid_pkg::CFG_IMAGE_HEIGHT:     reg_height = val;
            ppid_pkg::CFG_CHANNEL_COUNT:    reg_chan = val[5:0];
            ppid_pkg::CFG_WIDE_SAMPLES:     reg_wide = val[0];
            ppid_pkg::CFG_COMPRESSION_MODE: reg_mode = val[1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [18:0] w, input logic [18:0] h,
                                input logic [18:0] c, input logic [18:0] wide,
                                input logic [18:0] mode);
        drain_fills();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_one(ppid_pkg::CFG_IMAGE_WIDTH, w);
        write_one(ppid_pkg::CFG_IMAGE_HEIGHT, h);
        write_one(ppid_pkg::CFG_CHANNEL_COUNT, c);
        write_one(ppid_pkg::CFG_WIDE_SAMPLES, wide);
        write_one(ppid_pkg::CFG_COMPRESSION_MODE, mode);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_raw_directed();
        program_regs(2, 1, 2, 0, 19'(ppid_pkg::MODE_RAW));
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h77, 1'b0);  // past the final sample
        program_regs(1, 1, 1, 1, 19'(ppid_pkg::MODE_RAW));
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_rle_directed();
        program_regs(4, 2, 1, 0, 19'(ppid_pkg::MODE_RLE));
        for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
        send_byte(8'h80, 1'b0);  // no-op header
        send_byte(8'h01, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h81, 1'b0);  // 128-byte run overruns the scanline
        // sixteen-bit: odd repeat leaves a high byte pending, next run completes it
        program_regs(3, 1, 1, 1, 19'(ppid_pkg::MODE_RLE));
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h34, 1'b0);
    endtask

    task automatic test_unsupported_modes();
        program_regs(4, 4, 1, 0, 19'(MODE_ZIP));
        send_byte(8'h9C, 1'b1);
        program_regs(4, 4, 1, 0, 19'(MODE_ZIP_ALT));
        send_byte(8'h63, 1'b1);
    endtask

    task automatic test_register_extremes();
        program_regs(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF);
        send_byte(8'hA5, 1'b1);
        program_regs(0, 0, 0, 0, 19'(ppid_pkg::MODE_RAW));
        send_byte(8'h3C, 1'b1);
        program_regs(19'(MAX_DIM), 19'(MAX_DIM), 19'(MAX_CHAN), 1, 19'(ppid_pkg::MODE_RLE));
        send_byte(8'hC3, 1'b1);
        send_byte(8'h5A, 1'b0);
        program_regs(19'h7FFFF, 1, 19'h3F, 0, 19'(ppid_pkg::MODE_RAW));
        send_byte(8'hF0, 1'b1);
        send_byte(8'h0F, 1'b0);
    endtask

    task automatic test_backpressure();
        program_regs(8, 3, 2, 0, 19'(ppid_pkg::MODE_RAW));
        in_idle_on = 1'b0;
        hold_request = 80;
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
        drain_fills();
        in_idle_on = 1'b1;
        for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    function automatic int unsigned pick_run(int unsigned left, int unsigned lo);
        int unsigned hi;
        hi = (left < 128) ? left : 128;
        if ($urandom_range(0, 9) == 0) return hi;
        return $urandom_range(lo, hi);
    endfunction

    task automatic run_random_image();
        int unsigned w, h, c, lines, left, k, n, pick;
        logic wide;
        logic [1:0] mode;
        logic [7:0] hdr;
        bit inject, broke;
        pick = $urandom_range(0, 99);
        if (pick < 70) mode = ppid_pkg::MODE_RLE;
        else if (pick < 95) mode = ppid_pkg::MODE_RAW;
        else mode = pick[0] ? MODE_ZIP : MODE_ZIP_ALT;
        if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(64, 200);
            h = 1;
            c = 1;
        end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 3);
            c = $urandom_range(1, 3);
        end
        wide = 1'($urandom_range(0, 1));
        program_regs(19'(w), 19'(h), 19'(c), 19'(wide), 19'(mode));
        in_idle_on = ($urandom_range(0, 4) != 0);
        out_idle_on = ($urandom_range(0, 4) != 0);
        images++;
        if (mode == ppid_pkg::MODE_RAW) begin
            n = w * h * c * (wide ? 2 : 1);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
            for (int unsigned i = 0; i < n; i++) begin
                // live channel count change mid-image
                if (i == n / 2 && $urandom_range(0, 19) == 0)
                    program_regs(19'(w), 19'(h), 19'($urandom_range(1, 4)), 19'(wide),
                                 19'(mode));
                send_byte(8'($urandom_range(0, 255)), i == 0);
            end
        end else if (mode == ppid_pkg::MODE_RLE) begin
            lines = h * c;
            for (int unsigned i = 0; i < 2 * lines; i++)
                send_byte(8'($urandom_range(0, 255)), i == 0);
            inject = ($urandom_range(0, 9) == 0);
            broke = 1'b0;
            for (int unsigned ln = 0; ln < lines && !broke; ln++) begin
                left = w * (wide ? 2 : 1);
                while (left > 0 && !broke) begin
                    if (inject && left < 128 && $urandom_range(0, 3) == 0) begin
                        k = $urandom_range(left + 1, 128);
                        hdr = 8'(257 - k);
                        send_byte(hdr, 1'b0);
                        send_noise($urandom_range(0, 2));
                        broke = 1'b1;
                    end else if ($urandom_range(0, 19) == 0) begin
                        send_byte(8'h80, 1'b0);
                    end else if (left >= 2 && $urandom_range(0, 1) == 1) begin
                        k = pick_run(left, 2);
                        hdr = 8'(k - 1);
                        send_byte(hdr, 1'b0);
                        for (int unsigned j = 0; j < k; j++)
                            send_byte(8'($urandom_range(0, 255)), 1'b0);
                        left -= k;
                    end else begin
                        k = pick_run(left, 1);
                        hdr = (k == 1) ? 8'h00 : 8'(257 - k);
                        send_byte(hdr, 1'b0);
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                        left -= k;
                    end
                end
            end
        end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_noise($urandom_range(0, 2));
        end
        if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
    endtask

    task automatic test_random_images();
        int start;
        start = bytes_sent - noise_bytes;
        while (bytes_sent - noise_bytes - start < RANDOM_BYTES) run_random_image();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_raw_directed();
        test_rle_directed();
        test_unsupported_modes();
        test_register_extremes();
        test_backpressure();
        test_random_images();
        drain_fills();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d data bytes (%0d ignored) over %0d random images plus directed cases",
                 bytes_sent, noise_bytes, images);
        $display("raw, packbits and zip modes, 8/16-bit samples; %0d fill words, %0d mismatches",
                 words_seen, mismatches);
        if (mismatches == 0 && expected_fills.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ppid_pkg.sv
rtl/ppid_front.sv
rtl/ppid_queue.sv
rtl/ppid_back.sv
rtl/planar_packbits_image_decoder_unit.sv
tb/sv/tb_planar_packbits_image_decoder_unit.sv
